// ===== sv/b32dec_pkg.sv =====
// ----------------------------------------------------------------------------
// b32dec_pkg
// Shared types and character codes for the base32 text decoder.
// ----------------------------------------------------------------------------
package b32dec_pkg;

  localparam logic [7:0] PadChar   = 8'h3D;
  localparam logic [7:0] SpaceChar = 8'h20;
  localparam logic [7:0] TabChar   = 8'h09;
  localparam logic [7:0] CrChar    = 8'h0D;
  localparam logic [7:0] LowerA    = 8'h61;
  localparam logic [7:0] LowerZ    = 8'h7A;
  localparam logic [7:0] UpperA    = 8'h41;
  localparam logic [7:0] UpperZ    = 8'h5A;
  localparam logic [7:0] CaseGap   = 8'h20;
  localparam logic [7:0] Digit2    = 8'h32;
  localparam logic [7:0] Digit7    = 8'h37;
  localparam logic [7:0] DigitBias = 8'h18;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic       bad_symbol;
  } out_t;

endpackage

// ===== sv/base32_text_decoder_top.sv =====
// ----------------------------------------------------------------------------
// base32_text_decoder_top
// Streaming base32 decoder, one text character per input transfer.
//
// Input channel: in_valid_i / in_stall_o carry one character and a flag
// for the last character of a string. Skipped characters ('=', space,
// tab, LF, VT, FF, CR) give no result; letters and digits 2-7 add five
// bits each, and a decoded byte leaves once eight bits are held. An
// invalid character sets a sticky error and stops bytes until the end.
// Output channel: out_valid_o / out_stall_i carry at most one result per
// character; the last character always gives an end result with the
// error flag, and the decoder state then clears.
// One character per cycle while the skid register is empty; the decode is a single map, shift
// and compare pass between the input transfer and the result register.
// A two-entry output buffer (result register plus skid register) lets a
// character be taken while one result waits; in_stall_o rises only while
// the skid register is full.
// Reset clears the bit store, the error flag and both buffer entries.
// ----------------------------------------------------------------------------
module base32_text_decoder_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  b32dec_pkg::in_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output b32dec_pkg::out_t  out_data_o
);

  typedef enum logic [1:0] {
    SymSkip,
    SymData,
    SymBad
  } sym_kind_e;

  logic [6:0]       residual_q, residual_d;
  logic [2:0]       count_q, count_d;
  logic             error_q, error_d;
  logic             main_v_q, skid_v_q;
  b32dec_pkg::out_t main_q, skid_q;

  logic [7:0]       ch_fold;
  sym_kind_e        kind;
  logic [4:0]       sym;
  logic [11:0]      buf_w;
  logic [3:0]       cnt_w;
  logic [2:0]       cnt_left;
  logic [6:0]       mask;
  logic             have_byte;
  logic [7:0]       byte_w;
  logic             accept;
  logic             produce;
  logic             pop;
  b32dec_pkg::out_t res;

  // character map
  always_comb begin
    ch_fold = in_data_i.char_code;
    if (ch_fold >= b32dec_pkg::LowerA && ch_fold <= b32dec_pkg::LowerZ) begin
      ch_fold = ch_fold - b32dec_pkg::CaseGap;
    end
    kind = SymBad;
    sym  = '0;
    if (in_data_i.char_code == b32dec_pkg::PadChar ||
        in_data_i.char_code == b32dec_pkg::SpaceChar ||
        (in_data_i.char_code >= b32dec_pkg::TabChar &&
         in_data_i.char_code <= b32dec_pkg::CrChar)) begin
      kind = SymSkip;
    end else if (ch_fold >= b32dec_pkg::UpperA && ch_fold <= b32dec_pkg::UpperZ) begin
      kind = SymData;
      sym  = 5'(ch_fold - b32dec_pkg::UpperA);
    end else if (ch_fold >= b32dec_pkg::Digit2 && ch_fold <= b32dec_pkg::Digit7) begin
      kind = SymData;
      sym  = 5'(ch_fold - b32dec_pkg::DigitBias);
    end
  end

  // bit store update
  always_comb begin
    buf_w     = {residual_q, sym};
    cnt_w     = {1'b0, count_q} + 4'd5;
    have_byte = 1'b0;
    cnt_left  = cnt_w[2:0];
    if (cnt_w[3]) begin
      have_byte = 1'b1;
      cnt_left  = cnt_w[2:0];
    end
    byte_w  = have_byte ? 8'(buf_w >> cnt_left) : 8'h00;
    mask    = (7'h01 << cnt_left) - 7'h01;

    residual_d = residual_q;
    count_d    = count_q;
    error_d    = error_q;
    if (!error_q) begin
      if (kind == SymBad) begin
        error_d = 1'b1;
      end else if (kind == SymData) begin
        residual_d = buf_w[6:0] & mask;
        count_d    = cnt_left;
      end
    end
    if (error_q || kind != SymData) begin
      have_byte = 1'b0;
      byte_w    = 8'h00;
    end

    res.out_byte   = byte_w;
    res.byte_valid = have_byte;
    res.string_end = in_data_i.last_char;
    res.bad_symbol = in_data_i.last_char & error_d;
    produce        = have_byte | in_data_i.last_char;
  end

  assign in_stall_o  = skid_v_q;
  assign accept      = in_valid_i & ~skid_v_q;
  assign pop         = main_v_q & ~out_stall_i;
  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      residual_q <= '0;
      count_q    <= '0;
      error_q    <= 1'b0;
      main_v_q   <= 1'b0;
      skid_v_q   <= 1'b0;
      main_q     <= '0;
      skid_q     <= '0;
    end else begin
      if (accept) begin
        if (in_data_i.last_char) begin
          residual_q <= '0;
          count_q    <= '0;
          error_q    <= 1'b0;
        end else begin
          residual_q <= residual_d;
          count_q    <= count_d;
          error_q    <= error_d;
        end
      end
      if (skid_v_q) begin
        if (pop) begin
          main_q   <= skid_q;
          skid_v_q <= 1'b0;
        end
      end else if (accept && produce) begin
        if (!main_v_q || pop) begin
          main_q   <= res;
          main_v_q <= 1'b1;
        end else begin
          skid_q   <= res;
          skid_v_q <= 1'b1;
        end
      end else if (pop) begin
        main_v_q <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_main : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid entry held without a result entry");

  a_bad_only_at_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_symbol |-> out_data_o.string_end)
    else $error("error flag outside an end result");

  a_mid_has_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.string_end |-> out_data_o.byte_valid)
    else $error("result without byte or end marker");

  a_empty_byte_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.out_byte == 8'h00)
    else $error("nonzero byte without byte_valid");

  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(out_valid_o && out_stall_i) |-> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");
`endif

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the base32 text decoder. Character transfers
// pass through a queue-fed driver, and a local decoder model predicts each
// result. A monitor checks every output transfer field by field against
// the oldest prediction. Both channels idle and stall at random, and one
// long output hold-off fills the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int SymSkip    = -1;
  localparam int SymBad     = -2;
  localparam int DigitBase  = 26;
  localparam int ItemTarget = 1950;
  localparam int IdleLimit  = 4000;
  localparam int HoldStart  = 700;
  localparam int HoldCycles = 400;
  localparam int MaxPrints  = 40;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  b32dec_pkg::in_t  in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  b32dec_pkg::out_t out_data_o;

  base32_text_decoder_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  b32dec_pkg::in_t  char_queue[$];
  b32dec_pkg::out_t decoded_queue[$];

  logic [6:0] resid_bits = '0;
  logic [2:0] resid_count = '0;
  logic       bad_seen = 1'b0;

  int mismatch_count = 0;
  int chars_taken    = 0;
  int strings_sent   = 0;
  int bytes_seen     = 0;
  int ends_seen      = 0;
  int bad_ends       = 0;
  int idle_cycles    = 0;
  int in_gap         = 0;
  int in_calm        = 0;
  int out_gap        = 0;
  int out_calm       = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int symbol_value(input logic [7:0] ch);
    logic [7:0] up;
    up = ch;
    if (ch == b32dec_pkg::PadChar || ch == b32dec_pkg::SpaceChar ||
        (ch >= b32dec_pkg::TabChar && ch <= b32dec_pkg::CrChar)) return SymSkip;
    if (ch >= b32dec_pkg::LowerA && ch <= b32dec_pkg::LowerZ) up = ch - b32dec_pkg::CaseGap;
    if (up >= b32dec_pkg::UpperA && up <= b32dec_pkg::UpperZ)
      return int'(up - b32dec_pkg::UpperA);
    if (up >= b32dec_pkg::Digit2 && up <= b32dec_pkg::Digit7)
      return int'(up - b32dec_pkg::Digit2) + DigitBase;
    return SymBad;
  endfunction

  function automatic logic [7:0] alphabet_char();
    int idx;
    idx = $urandom_range(0, 31);
    if (idx >= DigitBase) return b32dec_pkg::Digit2 + 8'(idx - DigitBase);
    if ($urandom_range(0, 1) == 1) return b32dec_pkg::LowerA + 8'(idx);
    return b32dec_pkg::UpperA + 8'(idx);
  endfunction

  function automatic logic [7:0] filler_char();
    int r;
    r = $urandom_range(0, 6);
    if (r == 0) return b32dec_pkg::PadChar;
    if (r == 1) return b32dec_pkg::SpaceChar;
    return b32dec_pkg::TabChar + 8'(r - 2);
  endfunction

  function automatic logic [7:0] invalid_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255)); while (symbol_value(ch) != SymBad);
    return ch;
  endfunction

  // most gaps short, a few long, with calm stretches of no gaps at all
  function automatic int next_gap(inout int calm);
    int r;
    if (calm == 0 && $urandom_range(0, 149) == 0) calm = $urandom_range(30, 120);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic push_char(input logic [7:0] ch, input bit last);
    b32dec_pkg::in_t item;
    item.char_code = ch;
    item.last_char = last;
    char_queue.insert(char_queue.size(), item);
    if (last) strings_sent++;
  endtask

  task automatic push_text(input string s, input bit last);
    for (int i = 0; i < s.len(); i++) push_char(s[i], last && (i == s.len() - 1));
  endtask

  // decoder model: update the bit store and queue any result
  task automatic decode_char(input b32dec_pkg::in_t item);
    int               sym;
    int               cnt;
    logic [11:0]      acc;
    logic [7:0]       dec;
    bit               have;
    b32dec_pkg::out_t res;
    have = 1'b0;
    dec = '0;
    if (!bad_seen) begin
      sym = symbol_value(item.char_code);
      if (sym == SymBad) begin
        bad_seen = 1'b1;
      end else if (sym != SymSkip) begin
        acc = {5'b0, resid_bits} << 5 | 12'(sym);
        cnt = int'(resid_count) + 5;
        if (cnt >= 8) begin
          cnt -= 8;
          dec = 8'(acc >> cnt);
          have = 1'b1;
        end
        resid_bits = 7'(acc & ((12'd1 << cnt) - 12'd1));
        resid_count = 3'(cnt);
      end
    end
    res.out_byte   = dec;
    res.byte_valid = have;
    res.string_end = item.last_char;
    res.bad_symbol = item.last_char & bad_seen;
    if (item.last_char || have) decoded_queue.insert(decoded_queue.size(), res);
    if (item.last_char) begin
      resid_bits = '0;
      resid_count = '0;
      bad_seen = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MaxPrints)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) begin
        decode_char(in_data_i);
        chars_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (char_queue.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= char_queue.pop_front();
          in_gap = next_gap(in_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and output stall
  always @(posedge clk_i) begin
    b32dec_pkg::out_t want;
    if (rst_ni) begin
      if (out_fire) begin
        if (out_data_o.byte_valid) bytes_seen++;
        if (out_data_o.string_end) ends_seen++;
        if (out_data_o.string_end && out_data_o.bad_symbol) bad_ends++;
        if (decoded_queue.size() == 0) begin
          report_mismatch("unexpected transfer", int'(out_data_o), 0);
        end else begin
          want = decoded_queue.pop_front();
          if (out_data_o.out_byte !== want.out_byte)
            report_mismatch("out_byte", int'(out_data_o.out_byte), int'(want.out_byte));
          if (out_data_o.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", int'(out_data_o.byte_valid),
                            int'(want.byte_valid));
          if (out_data_o.string_end !== want.string_end)
            report_mismatch("string_end", int'(out_data_o.string_end),
                            int'(want.string_end));
          if (out_data_o.bad_symbol !== want.bad_symbol)
            report_mismatch("bad_symbol", int'(out_data_o.bad_symbol),
                            int'(want.bad_symbol));
        end
      end
      if (!hold_done && chars_taken >= HoldStart) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        out_gap = next_gap(out_calm);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (in_fire || out_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("[%0t] no transfer for %0d cycles", $realtime, idle_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int counted;
    int len;
    int kind;
    int bad_pos;
    int r;
    logic [7:0] ch;

    // directed strings
    push_text("mZxW6ytB", 1'b1);
    push_char("7", 1'b0);
    push_char(b32dec_pkg::TabChar, 1'b0);
    push_char("z", 1'b0);
    push_char(b32dec_pkg::PadChar, 1'b0);
    push_char(b32dec_pkg::SpaceChar, 1'b1);
    push_char("2", 1'b0);
    push_char(8'h0A, 1'b0);
    push_char(8'h0B, 1'b0);
    push_char(8'h0C, 1'b0);
    push_char(b32dec_pkg::CrChar, 1'b1);
    push_char("A", 1'b0);
    push_char(8'h00, 1'b0);
    push_char("B", 1'b0);
    push_char(8'hFF, 1'b1);
    push_char(8'h80, 1'b1);
    push_char(b32dec_pkg::PadChar, 1'b1);
    push_text("a1", 1'b1);

    // random strings, mostly well formed
    counted = char_queue.size();
    while (counted < ItemTarget) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 12);
      kind = $urandom_range(0, 99);
      bad_pos = (kind < 15) ? $urandom_range(0, len - 1) : -1;
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        if (k == bad_pos) ch = invalid_char();
        else if (kind >= 95) ch = 8'($urandom_range(0, 255));
        else if (r < 8) ch = filler_char();
        else ch = alphabet_char();
        push_char(ch, k == len - 1);
        counted++;
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (char_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (decoded_queue.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d characters in %0d strings with random idling and one long hold-off",
             chars_taken, strings_sent);
    $display("Checked %0d decoded bytes and %0d string ends, %0d of them flagged bad",
             bytes_seen, ends_seen, bad_ends);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
